>>> hw/rtl/lrt_pkg.sv
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and codes for the lru replacement tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int KEY_W    = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TOUCH   = 2'd0,
    MODE_PROTECT = 2'd1,
    MODE_EVICT   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             en;
    logic [MODE_W-1:0] mode;
    logic             found;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

>>> hw/rtl/lrt_cell.sv
// ----------------------------------------------------------------------------
// lrt_cell
// One slot of the recency chain: holds a key and its valid bit, compares the
// key against the command and takes its upper neighbor's contents on removal or move.
// ----------------------------------------------------------------------------
module lrt_cell
  import lrt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_cmd_t        cmd,
  input  logic [KEY_W-1:0] next_key,
  input  logic             next_valid,
  input  logic             prev_valid,
  input  logic             hit_in,
  output logic             hit_out,
  output logic [KEY_W-1:0] key_o,
  output logic             valid_o
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             valid_r, valid_nxt;
  logic             match;

  assign match   = valid_r && (key_r == cmd.key);
  assign hit_out = hit_in | match;
  assign key_o   = key_r;
  assign valid_o = valid_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.en) begin
      unique case (cmd.mode)
        MODE_TOUCH: begin
          if (cmd.found) begin
            if (hit_out) begin
              key_nxt = next_valid ? next_key : cmd.key;
            end
          end else if (!valid_r && prev_valid) begin
            key_nxt   = cmd.key;
            valid_nxt = 1'b1;
          end
        end
        MODE_PROTECT: begin
          if (hit_out) begin
            key_nxt   = next_key;
            valid_nxt = next_valid;
          end
        end
        MODE_EVICT: begin
          key_nxt   = next_key;
          valid_nxt = next_valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> hw/rtl/lru_replacement_tracker.sv
// result: registered; a result appears in the cycle after its input transfer
// throughput: one item per cycle while the result side does not stall
// the key search and shift ripple combinationally through the chain of slot cells
// reset: synchronous active-low; clears the slot valid bits and the output valid
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// Recency list of page keys kept in a chain of slot cells, least recent first.
// ----------------------------------------------------------------------------
module lru_replacement_tracker
  import lrt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [KEY_W-1:0]    in_page_key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_was_present,
  output logic [KEY_W-1:0]    out_victim_key
);

  logic [KEY_W-1:0] cell_key   [ENTRIES];
  logic             cell_valid [ENTRIES];
  logic [ENTRIES:0] hit_chain;
  cell_cmd_t        cmd;
  logic             accept;
  logic             full;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                present_r, present_nxt;
  logic [KEY_W-1:0]    victim_r, victim_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = cell_valid[ENTRIES-1];

  assign hit_chain[0] = 1'b0;
  assign cmd.en    = accept;
  assign cmd.mode  = in_mode;
  assign cmd.found = hit_chain[ENTRIES];
  assign cmd.key   = in_page_key;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] nk;
    logic             nv;
    logic             pv;
    if (i == ENTRIES - 1) begin : g_last
      assign nk = '0;
      assign nv = 1'b0;
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign nv = cell_valid[i+1];
    end
    if (i == 0) begin : g_first
      assign pv = 1'b1;
    end else begin : g_rest
      assign pv = cell_valid[i-1];
    end
    lrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .next_key   (nk),
      .next_valid (nv),
      .prev_valid (pv),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .key_o      (cell_key[i]),
      .valid_o    (cell_valid[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    present_nxt   = present_r;
    victim_nxt    = victim_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DONE;
      present_nxt   = 1'b0;
      victim_nxt    = '0;
      unique case (in_mode)
        MODE_TOUCH: begin
          present_nxt = cmd.found;
          if (!cmd.found && full) begin
            status_nxt = ST_FULL;
          end
        end
        MODE_PROTECT: begin
          present_nxt = cmd.found;
          if (!cmd.found) begin
            status_nxt = ST_ABSENT;
          end
        end
        MODE_EVICT: begin
          if (cell_valid[0]) begin
            victim_nxt = cell_key[0];
          end else begin
            status_nxt = ST_ABSENT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    present_r <= present_nxt;
    victim_r  <= victim_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_was_present = present_r;
  assign out_victim_key  = victim_r;

endmodule

>>> hw/rtl/lrt_checker.sv
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks for the lru replacement tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker
  import lrt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status,
  input logic                out_was_present,
  input logic [KEY_W-1:0]    out_victim_key
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("transfer without a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_victim_key)))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_ABSENT
      || out_status == ST_FULL))
    else $error("bad status code");

  a_victim_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_victim_key != '0 || out_was_present))
      |-> (out_status == ST_DONE))
    else $error("victim or hit with failing status");

endmodule

bind lru_replacement_tracker lrt_checker u_lrt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_was_present (out_was_present),
  .out_victim_key  (out_victim_key)
);

>>> test/lru_replacement_tracker_check.sv
// ----------------------------------------------------------------------------
// lru_replacement_tracker_check
// Watches both channels of the tracker, keeps its own recency list, works out
// the result of every input transfer and compares each result transfer with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_check
  import lrt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [KEY_W-1:0]    in_page_key,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic                out_was_present,
  input  logic [KEY_W-1:0]    out_victim_key,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic                was_present;
    logic [KEY_W-1:0]    victim;
  } lru_result_t;

  lru_result_t      expected_q[$];
  logic [KEY_W-1:0] recency_q[$];
  int               errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic lru_result_t predict_access(logic [MODE_W-1:0] mode,
                                                 logic [KEY_W-1:0] key);
    lru_result_t r;
    int          pos;
    r.status      = ST_DONE;
    r.was_present = 1'b0;
    r.victim      = '0;
    pos           = -1;
    foreach (recency_q[i])
      if (pos < 0 && recency_q[i] == key) pos = i;
    case (mode)
      MODE_TOUCH: begin
        if (pos >= 0) begin
          r.was_present = 1'b1;
          recency_q.delete(pos);
          recency_q.push_back(key);
        end else if (recency_q.size() >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          recency_q.push_back(key);
        end
      end
      MODE_PROTECT: begin
        if (pos >= 0) begin
          r.was_present = 1'b1;
          recency_q.delete(pos);
        end else begin
          r.status = ST_ABSENT;
        end
      end
      MODE_EVICT: begin
        if (recency_q.size() == 0) r.status = ST_ABSENT;
        else r.victim = recency_q.pop_front();
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    lru_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      recency_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected: status %0d was_present %0d victim_key %h",
                 out_status, out_was_present, out_victim_key);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, out_was_present);
            errors++;
          end
          if (out_victim_key !== want.victim) begin
            $error("victim_key: expected %h, got %h", want.victim, out_victim_key);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_access(in_mode, in_page_key));
      pending <= expected_q.size();
    end
    fail_count <= errors;
  end

endmodule

>>> test/lru_replacement_tracker_test.sv
// ----------------------------------------------------------------------------
// lru_replacement_tracker_test
// Drives the tracker with a directed opening (empty list, full list, moves,
// removals, the spare mode code) followed by random accesses over a small key
// pool, under several sender idle and receiver stall mixes, a long receiver
// hold-off and drains between phases. A checker beside the block scores it.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_test;
  import lrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                ENTRIES     = 16;
  localparam int                POOL        = 24;
  localparam int                HOLD_CYCLES = 64;
  localparam int                PHASE_ITEMS = 440;
  localparam int                CYCLE_LIMIT = 200000;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode = MODE_TOUCH;
  logic [KEY_W-1:0]    in_page_key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_was_present;
  logic [KEY_W-1:0]    out_victim_key;

  int               fail_count;
  int               pending;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               hold_asked = 0;
  int               hold_granted = 0;
  int               hold_left = 0;
  int               cycle_count = 0;
  logic [KEY_W-1:0] key_pool[POOL];

  always #2 clk = ~clk;

  lru_replacement_tracker #(.ENTRIES(ENTRIES)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_page_key     (in_page_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_was_present (out_was_present),
    .out_victim_key  (out_victim_key)
  );

  lru_replacement_tracker_check #(.ENTRIES(ENTRIES)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_page_key     (in_page_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_was_present (out_was_present),
    .out_victim_key  (out_victim_key),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // receiver: random stall, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_granted != hold_asked) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      hold_granted <= hold_granted + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_page_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender stops until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random(input int evict_wt);
    int               pick;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    pick = $urandom_range(99);
    if (pick < 5) mode = MODE_SPARE;
    else if (pick < 5 + evict_wt) mode = MODE_EVICT;
    else if (pick < 25 + evict_wt) mode = MODE_PROTECT;
    else mode = MODE_TOUCH;
    if ($urandom_range(9) == 0) key = $urandom();
    else key = key_pool[$urandom_range(POOL - 1)];
    send_item(mode, key);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int evict_tab[4];
    idle_tab  = '{0, 59, 0, 27};
    stall_tab = '{0, 0, 59, 27};
    evict_tab = '{25, 15, 35, 25};
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, key extremes, move to most recent, removal, spare code
    send_item(MODE_EVICT, 32'h0000_0000);
    send_item(MODE_PROTECT, 32'hFFFF_FFFF);
    send_item(MODE_TOUCH, 32'h0000_0000);
    send_item(MODE_TOUCH, 32'hFFFF_FFFF);
    send_item(MODE_TOUCH, 32'h0000_0000);
    send_item(MODE_PROTECT, 32'hFFFF_FFFF);
    send_item(MODE_SPARE, 32'hFFFF_FFFF);
    // fill up, refuse a new key, move a present key on a full list
    for (int i = 1; i < ENTRIES; i++) send_item(MODE_TOUCH, 32'hC000_0000 + i);
    send_item(MODE_TOUCH, 32'h7FFF_FFFF);
    send_item(MODE_TOUCH, 32'h0000_0000);
    send_item(MODE_EVICT, 32'hFFFF_FFFF);
    drain();

    // long receiver hold-off with the sender pushing
    hold_asked <= hold_asked + 1;
    for (int i = 0; i < 30; i++) send_random(25);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_tab[p];
      stall_pct <= stall_tab[p];
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(evict_tab[p]);
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
